// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion macros shared by the rotation block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, off while reset is high
`define EVR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication
`define EVR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EVR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/evr_pkg.sv =====
// ----------------------------------------------------------------------------
// evr_pkg
// shared types, codes and tables of the euler vector rotation block
// ----------------------------------------------------------------------------
package evr_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int ANGLE_W     = 16;
  localparam int TRIG_W      = 32;
  localparam int NUM_COEF    = 9;
  localparam int NUM_STEPS   = 15;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROLL  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PITCH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_YAW   = 2'd2;

  typedef enum logic [2:0] {
    T_IDLE, T_X, T_X2, T_MUL, T_DIV, T_SUB, T_SIN, T_FIN
  } trig_state_t;

  typedef enum logic [2:0] {
    C_IDLE, C_LAUNCH, C_TRIG, C_MUL, C_ACC
  } coef_state_t;

  typedef enum logic [3:0] {
    SRC_SR, SRC_CR, SRC_SP, SRC_CP, SRC_SY, SRC_CY, SRC_TA, SRC_TB, SRC_NEG_ONE
  } src_t;

  typedef enum logic [1:0] {OP_SET, OP_ADD, OP_SUB} acc_op_t;

  typedef enum logic [1:0] {DST_NONE, DST_TA, DST_TB, DST_COEF} dst_t;

  typedef struct packed {
    src_t    a;
    src_t    b;
    acc_op_t op;
    dst_t    dst;
    logic [3:0] idx;
  } uop_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } lane_ctl_t;

  // horner term divisors 72 42 20 6, then 90 56 30 12 2, as reciprocals:
  // floor(n / d) equals (n * recip) >> shift for every n below 2^30
  function automatic logic [30:0] evr_term_recip(input logic [3:0] ti);
    logic [30:0] m;
    case (ti)
      4'd0: m = 31'd1908874354;
      4'd1: m = 31'd1636178018;
      4'd2: m = 31'd1717986919;
      4'd3: m = 31'd1431655766;
      4'd4: m = 31'd1527099484;
      4'd5: m = 31'd1227133514;
      4'd6: m = 31'd1145324613;
      4'd7: m = 31'd1431655766;
      default: m = 31'd1073741824;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] evr_term_shift(input logic [3:0] ti);
    logic [5:0] sh;
    case (ti)
      4'd0: sh = 6'd37;
      4'd1: sh = 6'd36;
      4'd2: sh = 6'd35;
      4'd3: sh = 6'd33;
      4'd4: sh = 6'd37;
      4'd5: sh = 6'd36;
      4'd6: sh = 6'd35;
      4'd7: sh = 6'd34;
      default: sh = 6'd31;
    endcase
    return sh;
  endfunction

  // matrix build program
  function automatic uop_t evr_uop(input logic [3:0] step);
    uop_t u;
    case (step)
      4'd0:  u = '{SRC_CP, SRC_CY, OP_SET, DST_COEF, 4'd0};
      4'd1:  u = '{SRC_CY, SRC_SP, OP_SET, DST_TA,   4'd0};
      4'd2:  u = '{SRC_TA, SRC_SR, OP_SET, DST_NONE, 4'd0};
      4'd3:  u = '{SRC_SY, SRC_CR, OP_SUB, DST_COEF, 4'd1};
      4'd4:  u = '{SRC_SY, SRC_SR, OP_SET, DST_NONE, 4'd0};
      4'd5:  u = '{SRC_TA, SRC_CR, OP_ADD, DST_COEF, 4'd2};
      4'd6:  u = '{SRC_CP, SRC_SY, OP_SET, DST_COEF, 4'd3};
      4'd7:  u = '{SRC_SY, SRC_SP, OP_SET, DST_TB,   4'd0};
      4'd8:  u = '{SRC_TB, SRC_SR, OP_SET, DST_NONE, 4'd0};
      4'd9:  u = '{SRC_CY, SRC_CR, OP_ADD, DST_COEF, 4'd4};
      4'd10: u = '{SRC_TB, SRC_CR, OP_SET, DST_NONE, 4'd0};
      4'd11: u = '{SRC_CY, SRC_SR, OP_SUB, DST_COEF, 4'd5};
      4'd12: u = '{SRC_CP, SRC_SR, OP_SET, DST_COEF, 4'd7};
      4'd13: u = '{SRC_CP, SRC_CR, OP_SET, DST_COEF, 4'd8};
      default: u = '{SRC_SP, SRC_NEG_ONE, OP_SET, DST_COEF, 4'd6};
    endcase
    return u;
  endfunction

endpackage

// ===== sv/evr_in_if.sv =====
// ----------------------------------------------------------------------------
// evr_in_if
// input vector channel: valid, ready and three components
// ----------------------------------------------------------------------------
interface evr_in_if #(parameter int DATA_WIDTH = 32) ();
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] vec_x;
  logic signed [DATA_WIDTH-1:0] vec_y;
  logic signed [DATA_WIDTH-1:0] vec_z;

  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

// ===== sv/evr_out_if.sv =====
// ----------------------------------------------------------------------------
// evr_out_if
// rotated vector channel: valid, ready and three components
// ----------------------------------------------------------------------------
interface evr_out_if #(parameter int DATA_WIDTH = 32) ();
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] rot_x;
  logic signed [DATA_WIDTH-1:0] rot_y;
  logic signed [DATA_WIDTH-1:0] rot_z;

  modport source (output valid, rot_x, rot_y, rot_z, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

// ===== sv/evr_trig.sv =====
// ----------------------------------------------------------------------------
// evr_trig
// sequential sine and cosine of one angle in q30, taylor series
// ----------------------------------------------------------------------------
module evr_trig (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [evr_pkg::ANGLE_W-1:0] angle,
  output logic done,
  output logic signed [evr_pkg::TRIG_W-1:0] sin_q,
  output logic signed [evr_pkg::TRIG_W-1:0] cos_q
);
  import evr_pkg::*;

  localparam logic signed [17:0] FULL    = 18'sd23040;
  localparam logic [14:0] QUARTER        = 15'd5760;
  localparam logic [14:0] EIGHTH         = 15'd2880;
  localparam logic [30:0] RAD_Q40        = 31'd299845282;
  localparam logic [30:0] ONE            = 31'h4000_0000;
  localparam logic [61:0] HALF_Q30       = 62'h2000_0000;

  trig_state_t state, state_next;

  logic [11:0] units;
  logic swap;
  logic [1:0] quad;
  logic [30:0] x, x2, t, s, dvd;
  logic [3:0] ti;

  // angle reduction to a turn, quadrant and fold to an eighth turn
  logic signed [17:0] a_ext, r18;
  logic [14:0] r, f;
  logic [1:0] quad_new;
  logic [11:0] units_new;
  logic swap_new;

  always_comb begin
    a_ext = {{2{angle[ANGLE_W-1]}}, angle};
    if (a_ext >= FULL) begin
      r18 = a_ext - FULL;
    end else if (a_ext >= 18'sd0) begin
      r18 = a_ext;
    end else if (a_ext >= -FULL) begin
      r18 = a_ext + FULL;
    end else begin
      r18 = a_ext + FULL + FULL;
    end
    r = r18[14:0];
    if (r >= 15'd17280) begin
      quad_new = 2'd3;
      f = r - 15'd17280;
    end else if (r >= 15'd11520) begin
      quad_new = 2'd2;
      f = r - 15'd11520;
    end else if (r >= QUARTER) begin
      quad_new = 2'd1;
      f = r - QUARTER;
    end else begin
      quad_new = 2'd0;
      f = r;
    end
    if (f <= EIGHTH) begin
      units_new = f[11:0];
      swap_new = 1'b0;
    end else begin
      units_new = 12'(QUARTER - f);
      swap_new = 1'b1;
    end
  end

  // divide by a small constant: reciprocal multiply, then shift
  logic [30:0] recip;
  logic [5:0] div_sh;

  // shared multiplier
  logic [30:0] mul_a, mul_b;
  logic [61:0] prod, prod_rnd, quo;

  always_comb begin
    case (state)
      T_X: begin
        mul_a = {19'd0, units};
        mul_b = RAD_Q40;
      end
      T_X2: begin
        mul_a = x;
        mul_b = x;
      end
      T_MUL: begin
        mul_a = x2;
        mul_b = t;
      end
      T_DIV: begin
        mul_a = dvd;
        mul_b = recip;
      end
      T_SIN: begin
        mul_a = x;
        mul_b = t;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign prod_rnd = prod + HALF_Q30;

  always_comb begin
    recip = evr_term_recip(ti);
    div_sh = evr_term_shift(ti);
    quo = prod >> div_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE: state_next = T_IDLE;
      T_X:    state_next = T_X2;
      T_X2:   state_next = T_MUL;
      T_MUL:  state_next = T_DIV;
      T_DIV:  state_next = T_SUB;
      T_SUB: begin
        if (ti == 4'd3) begin
          state_next = T_SIN;
        end else if (ti == 4'd8) begin
          state_next = T_FIN;
        end else begin
          state_next = T_MUL;
        end
      end
      T_SIN:  state_next = T_MUL;
      T_FIN:  state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
    if (start) state_next = T_X;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      units <= units_new;
      swap <= swap_new;
      quad <= quad_new;
      ti <= '0;
    end else begin
      case (state)
        T_X: x <= prod[40:10];
        T_X2: begin
          x2 <= prod_rnd[60:30];
          t <= ONE;
        end
        T_MUL: dvd <= prod[60:30];
        T_DIV: dvd <= quo[30:0];
        T_SUB: begin
          t <= ONE - dvd;
          ti <= ti + 4'd1;
        end
        T_SIN: begin
          s <= prod[60:30];
          t <= ONE;
        end
        default: ;
      endcase
    end
  end

  // undo the fold and place the quadrant
  logic signed [TRIG_W-1:0] fs, fc;

  always_comb begin
    fs = swap ? {1'b0, t} : {1'b0, s};
    fc = swap ? {1'b0, s} : {1'b0, t};
    case (quad)
      2'd0: begin
        sin_q = fs;
        cos_q = fc;
      end
      2'd1: begin
        sin_q = fc;
        cos_q = -fs;
      end
      2'd2: begin
        sin_q = -fs;
        cos_q = -fc;
      end
      default: begin
        sin_q = -fc;
        cos_q = fs;
      end
    endcase
  end

  assign done = (state == T_FIN);

endmodule

// ===== sv/evr_coef.sv =====
// ----------------------------------------------------------------------------
// evr_coef
// angle registers and rotation matrix builder
// ----------------------------------------------------------------------------
module evr_coef #(
  parameter int COEF_WIDTH = 18
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [evr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [evr_pkg::ANGLE_W-1:0] cfg_data,
  output logic busy,
  output logic signed [COEF_WIDTH-1:0] coef [evr_pkg::NUM_COEF]
);
  import evr_pkg::*;

  localparam int SH = 62 - COEF_WIDTH;
  localparam logic signed [63:0] RND = 64'sd1 <<< (SH - 1);
  localparam logic signed [63:0] CMAX = (64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] CMIN = -(64'sd1 <<< (COEF_WIDTH - 1));
  localparam logic signed [63:0] HALF_Q30 = 64'sd1 <<< 29;
  localparam logic signed [TRIG_W-1:0] NEG_ONE = -(32'sd1 <<< 30);
  localparam logic signed [COEF_WIDTH-1:0] UNIT = COEF_WIDTH'(1) <<< (COEF_WIDTH - 2);

  coef_state_t state, state_next;

  logic [ANGLE_W-1:0] roll, pitch, yaw;
  logic [1:0] ai;
  logic [3:0] step;
  logic signed [TRIG_W-1:0] sn [3];
  logic signed [TRIG_W-1:0] cs [3];
  logic signed [TRIG_W-1:0] ta, tb;
  logic signed [63:0] prod, acc;

  logic wr_ok;
  logic [ANGLE_W-1:0] cur_angle;
  logic trig_done;
  logic signed [TRIG_W-1:0] trig_sin, trig_cos;

  assign wr_ok = cfg_write &&
                 (cfg_index == REG_ROLL || cfg_index == REG_PITCH || cfg_index == REG_YAW);

  always_comb begin
    case (ai)
      2'd1: cur_angle = pitch;
      2'd2: cur_angle = yaw;
      default: cur_angle = roll;
    endcase
  end

  evr_trig u_trig (
    .clk   (clk),
    .rst   (rst),
    .start (state == C_LAUNCH),
    .angle (signed'(cur_angle)),
    .done  (trig_done),
    .sin_q (trig_sin),
    .cos_q (trig_cos)
  );

  function automatic logic signed [TRIG_W-1:0] pick(
    input src_t sel,
    input logic signed [TRIG_W-1:0] sr, cr, sp, cp, sy, cy, a, b
  );
    logic signed [TRIG_W-1:0] v;
    case (sel)
      SRC_SR: v = sr;
      SRC_CR: v = cr;
      SRC_SP: v = sp;
      SRC_CP: v = cp;
      SRC_SY: v = sy;
      SRC_CY: v = cy;
      SRC_TA: v = a;
      SRC_TB: v = b;
      default: v = NEG_ONE;
    endcase
    return v;
  endfunction

  uop_t uop;
  logic signed [TRIG_W-1:0] opa, opb;
  logic signed [63:0] acc_next, ta_full, ta_sh, c_rnd, c_sh;
  logic signed [COEF_WIDTH-1:0] c_sat;

  always_comb begin
    uop = evr_uop(step);
    opa = pick(uop.a, sn[0], cs[0], sn[1], cs[1], sn[2], cs[2], ta, tb);
    opb = pick(uop.b, sn[0], cs[0], sn[1], cs[1], sn[2], cs[2], ta, tb);
    case (uop.op)
      OP_ADD: acc_next = acc + prod;
      OP_SUB: acc_next = acc - prod;
      default: acc_next = prod;
    endcase
    ta_full = acc_next + HALF_Q30;
    ta_sh = ta_full >>> 30;
    c_rnd = acc_next + RND;
    c_sh = c_rnd >>> SH;
    if (c_sh > CMAX) begin
      c_sat = CMAX[COEF_WIDTH-1:0];
    end else if (c_sh < CMIN) begin
      c_sat = CMIN[COEF_WIDTH-1:0];
    end else begin
      c_sat = c_sh[COEF_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      C_IDLE:   state_next = C_IDLE;
      C_LAUNCH: state_next = C_TRIG;
      C_TRIG: begin
        if (trig_done) state_next = (ai == 2'd2) ? C_MUL : C_LAUNCH;
      end
      C_MUL:    state_next = C_ACC;
      C_ACC: begin
        state_next = (step == 4'(NUM_STEPS - 1)) ? C_IDLE : C_MUL;
      end
      default:  state_next = C_IDLE;
    endcase
    if (wr_ok) state_next = C_LAUNCH;
  end

  assign busy = (state != C_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      roll <= '0;
      pitch <= '0;
      yaw <= '0;
      for (int k = 0; k < NUM_COEF; k++) begin
        coef[k] <= (k % 4 == 0) ? UNIT : '0;
      end
    end else if (wr_ok) begin
      case (cfg_index)
        REG_ROLL:  roll <= cfg_data;
        REG_PITCH: pitch <= cfg_data;
        default:   yaw <= cfg_data;
      endcase
    end else if (state == C_ACC && uop.dst == DST_COEF) begin
      coef[uop.idx] <= c_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      ai <= '0;
      step <= '0;
    end else begin
      case (state)
        C_TRIG: begin
          if (trig_done) begin
            sn[ai] <= trig_sin;
            cs[ai] <= trig_cos;
            ai <= ai + 2'd1;
          end
        end
        C_MUL: prod <= opa * opb;
        C_ACC: begin
          acc <= acc_next;
          step <= step + 4'd1;
          if (uop.dst == DST_TA) ta <= ta_sh[TRIG_W-1:0];
          if (uop.dst == DST_TB) tb <= ta_sh[TRIG_W-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/evr_lane.sv =====
// ----------------------------------------------------------------------------
// evr_lane
// one matrix row times the vector, rounded and saturated
// ----------------------------------------------------------------------------
module evr_lane #(
  parameter int DATA_WIDTH = 32,
  parameter int COEF_WIDTH = 18
) (
  input  logic clk,
  input  evr_pkg::lane_ctl_t ctl,
  input  logic signed [COEF_WIDTH-1:0] row [3],
  input  logic signed [DATA_WIDTH-1:0] vec [3],
  output logic signed [DATA_WIDTH-1:0] result
);
  import evr_pkg::*;

  localparam int HIW = DATA_WIDTH - 15;
  localparam int PHW = COEF_WIDTH + HIW;
  localparam int PLW = COEF_WIDTH + 17;
  localparam int HSW = PHW + 2;
  localparam int LSW = COEF_WIDTH + 19;
  localparam int TW  = COEF_WIDTH + DATA_WIDTH + 4;
  localparam int CF  = COEF_WIDTH - 2;
  localparam logic signed [LSW-1:0] HALF = LSW'(1) <<< (CF - 1);
  localparam logic signed [TW-1:0] DMAX = TW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] DMIN = TW'(-(64'sd1 <<< (DATA_WIDTH - 1)));

  logic signed [PHW-1:0] ph [3];
  logic signed [PLW-1:0] pl [3];
  logic signed [HSW-1:0] hsum;
  logic signed [LSW-1:0] lsum;

  // split each component into a signed high part and an unsigned low half
  logic signed [DATA_WIDTH-1:0] v_sh [3];
  logic signed [HIW-1:0] hi [3];
  logic signed [16:0] lo [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_sh[i] = vec[i] >>> 16;
      hi[i] = v_sh[i][HIW-1:0];
      lo[i] = {1'b0, vec[i][15:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      for (int i = 0; i < 3; i++) begin
        ph[i] <= row[i] * hi[i];
        pl[i] <= row[i] * lo[i];
      end
    end
    if (ctl.s2_en) begin
      hsum <= HSW'(ph[0]) + HSW'(ph[1]) + HSW'(ph[2]);
      lsum <= LSW'(pl[0]) + LSW'(pl[1]) + LSW'(pl[2]) + HALF;
    end
  end

  logic signed [TW-1:0] total, scaled;

  always_comb begin
    total = (TW'(hsum) <<< 16) + TW'(lsum);
    scaled = total >>> CF;
    if (scaled > DMAX) begin
      result = DMAX[DATA_WIDTH-1:0];
    end else if (scaled < DMIN) begin
      result = DMIN[DATA_WIDTH-1:0];
    end else begin
      result = scaled[DATA_WIDTH-1:0];
    end
  end

endmodule

// ===== sv/euler_vector_rotation.sv =====
// ----------------------------------------------------------------------------
// euler_vector_rotation
// z-y-x euler rotation of a stream of q16.16 vectors
// ----------------------------------------------------------------------------
// usage
//   cfg_write/cfg_index/cfg_data set roll (0), pitch (1) and yaw (2) in
//   1/64 degree units; other indexes are dropped. every accepted write
//   rebuilds the nine q2.x coefficients: three sine/cosine runs on one shared
//   multiplier, divides done by reciprocal multiply, then the matrix products.
//   in.ready stays low during a rebuild; a write during a rebuild restarts it.
//   in carries one word per vector, out one word per rotated vector.
//   three row lanes multiply in parallel: products, row sums, then the
//   merging output register with rounding and saturation. out.valid rises
//   once a word has passed the product and row-sum registers, and one word is
//   taken every cycle while out.ready stays high and no rebuild runs.
//   reset clears the angles to zero, loads the identity matrix and empties
//   the pipeline. when out stalls, empty stages ahead of it keep filling,
//   so up to three words wait inside before in.ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module euler_vector_rotation #(
  parameter int DATA_WIDTH = 32,
  parameter int COEF_WIDTH = 18
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [evr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [evr_pkg::ANGLE_W-1:0] cfg_data,
  evr_in_if.sink in,
  evr_out_if.source out
);
  import evr_pkg::*;

  // coefficient builder
  logic busy;
  logic signed [COEF_WIDTH-1:0] coef [NUM_COEF];

  evr_coef #(.COEF_WIDTH(COEF_WIDTH)) u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .coef      (coef)
  );

  // stage occupancy: v1 products, v2 row sums, v3 output register
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic adv1, adv2, adv3;

  // a stage takes a word when it is empty or its word moves on
  assign rdy3 = !v3 || out.ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign adv3 = v2 && rdy3;
  assign adv2 = v1 && rdy2;

  // no new vectors while coefficients are being rebuilt
  assign in.ready = rdy1 && !busy;
  assign adv1 = in.valid && in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= adv1;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  lane_ctl_t ctl;
  assign ctl.s1_en = adv1;
  assign ctl.s2_en = adv2;

  logic signed [DATA_WIDTH-1:0] vec [3];
  assign vec[0] = in.vec_x;
  assign vec[1] = in.vec_y;
  assign vec[2] = in.vec_z;

  // one lane per matrix row
  logic signed [COEF_WIDTH-1:0] row [3][3];
  logic signed [DATA_WIDTH-1:0] res [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    for (genvar i = 0; i < 3; i++) begin : g_tap
      assign row[k][i] = coef[3 * k + i];
    end
    evr_lane #(
      .DATA_WIDTH (DATA_WIDTH),
      .COEF_WIDTH (COEF_WIDTH)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .row    (row[k]),
      .vec    (vec),
      .result (res[k])
    );
  end

  // merging stage: the three lane results form one output word
  logic signed [DATA_WIDTH-1:0] x_out, y_out, z_out;

  always_ff @(posedge clk) begin
    if (adv3) begin
      x_out <= res[0];
      y_out <= res[1];
      z_out <= res[2];
    end
  end

  assign out.valid = v3;
  assign out.rot_x = x_out;
  assign out.rot_y = y_out;
  assign out.rot_z = z_out;

  logic cfg_known;
  assign cfg_known = cfg_write &&
                     (cfg_index == REG_ROLL || cfg_index == REG_PITCH || cfg_index == REG_YAW);

  // a register write must hold off vectors until the matrix is rebuilt
  `EVR_ASSERT_NEXT(a_cfg_blocks_input, cfg_known, !in.ready, "vector taken during rebuild")
  // a word shows up at the output only after passing the sum stage
  `EVR_ASSERT_IMP(a_out_from_sums, $rose(v3), $past(v2), "output word skipped a stage")
  // an accepted vector always lands in the product stage
  `EVR_ASSERT_NEXT(a_accept_fills, in.valid && in.ready, v1, "accepted vector lost")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stream test of the z-y-x euler vector rotation block
// ----------------------------------------------------------------------------
// a clocked driver feeds vectors from a queue and a clocked monitor checks
// every rotated word against a bit-exact fixed point model of the rotation
// matrix kept in step with the angle writes. angles are changed only while
// the block is idle; sender gaps and receiver stalls vary per phase.
// ----------------------------------------------------------------------------
module tb;
  import evr_pkg::*;

  localparam int DW         = 32;
  localparam int CW         = 18;
  localparam int FULL_UNITS = 23040;
  localparam int QTR_UNITS  = 5760;
  localparam int OCT_UNITS  = 2880;
  localparam longint ONE_Q30 = 64'sd1 <<< 30;
  localparam int WATCHDOG   = 20000;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3; // unused index, dropped

  typedef struct {
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic [DW-1:0] z;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ANGLE_W-1:0] cfg_data = '0;

  evr_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  evr_out_if #(.DATA_WIDTH(DW)) out_ch ();

  euler_vector_rotation #(.DATA_WIDTH(DW), .COEF_WIDTH(CW)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in(in_ch), .out(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model state: the three angles and the nine q2.16 coefficients
  logic [ANGLE_W-1:0] angle_q[3];
  longint coef_q[9];

  vec_t pending_vecs[$];   // vectors still to be sent
  vec_t expected_rot[$];   // rotated words still to arrive
  int idle_pct = 0;        // sender gap chance, percent
  int stall_pct = 0;       // receiver stall chance, percent
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic longint sat(input longint v, input int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // taylor sine and cosine in q30 for 0..45 degrees
  task automatic taylor_q30(input longint units, output longint s, output longint c);
    longint x, x2, t;
    x  = (units * 64'sd299845282) >>> 10;
    x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
    t = ONE_Q30 - (((x2 * ONE_Q30) >>> 30) / 72);
    t = ONE_Q30 - (((x2 * t) >>> 30) / 42);
    t = ONE_Q30 - (((x2 * t) >>> 30) / 20);
    t = ONE_Q30 - (((x2 * t) >>> 30) / 6);
    s = (x * t) >>> 30;
    t = ONE_Q30 - (((x2 * ONE_Q30) >>> 30) / 90);
    t = ONE_Q30 - (((x2 * t) >>> 30) / 56);
    t = ONE_Q30 - (((x2 * t) >>> 30) / 30);
    t = ONE_Q30 - (((x2 * t) >>> 30) / 12);
    c = ONE_Q30 - (((x2 * t) >>> 30) / 2);
  endtask

  // full-circle sine/cosine: wrap, fold by quadrant and octant
  task automatic angle_sin_cos(input logic [ANGLE_W-1:0] raw, output longint s,
                               output longint c);
    longint a, f, fs, fc;
    a = longint'($signed(raw)) % FULL_UNITS;
    if (a < 0) a += FULL_UNITS;
    f = a % QTR_UNITS;
    if (f <= OCT_UNITS) taylor_q30(f, fs, fc);
    else taylor_q30(QTR_UNITS - f, fc, fs);
    case (a / QTR_UNITS)
      0: begin s = fs;  c = fc;  end
      1: begin s = fc;  c = -fs; end
      2: begin s = -fs; c = -fc; end
      default: begin s = -fc; c = fs; end
    endcase
  endtask

  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint q60_to_coef(input longint v);
    return sat((v + (64'sd1 <<< 43)) >>> 44, CW);
  endfunction

  task automatic build_rotation();
    longint sr, cr, sp, cp, sy, cy, ysp, csp;
    angle_sin_cos(angle_q[REG_ROLL], sr, cr);
    angle_sin_cos(angle_q[REG_PITCH], sp, cp);
    angle_sin_cos(angle_q[REG_YAW], sy, cy);
    csp = mul_q30(cy, sp);
    ysp = mul_q30(sy, sp);
    coef_q[0] = q60_to_coef(cp * cy);
    coef_q[1] = q60_to_coef(csp * sr - sy * cr);
    coef_q[2] = q60_to_coef(sy * sr + csp * cr);
    coef_q[3] = q60_to_coef(cp * sy);
    coef_q[4] = q60_to_coef(ysp * sr + cy * cr);
    coef_q[5] = q60_to_coef(ysp * cr - cy * sr);
    coef_q[6] = q60_to_coef(-sp * ONE_Q30);
    coef_q[7] = q60_to_coef(cp * sr);
    coef_q[8] = q60_to_coef(cp * cr);
  endtask

  // row dot products, round half up, saturate to q16.16
  function automatic vec_t rotate_vec(input vec_t v);
    vec_t r;
    longint comp[3], acc[3];
    comp[0] = longint'($signed(v.x));
    comp[1] = longint'($signed(v.y));
    comp[2] = longint'($signed(v.z));
    for (int k = 0; k < 3; k++) begin
      acc[k] = 0;
      for (int i = 0; i < 3; i++) acc[k] += coef_q[3 * k + i] * comp[i];
      acc[k] = sat((acc[k] + 64'sd32768) >>> 16, DW);
    end
    r.x = acc[0][DW-1:0];
    r.y = acc[1][DW-1:0];
    r.z = acc[2][DW-1:0];
    return r;
  endfunction

  // input driver: hold a word until taken, then maybe leave a gap
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_vecs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        vec_t v;
        v = pending_vecs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.vec_x <= v.x;
        in_ch.vec_y <= v.y;
        in_ch.vec_z <= v.z;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // predict on acceptance, check on delivery, watchdog on silence
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      vec_t v;
      v.x = in_ch.vec_x;
      v.y = in_ch.vec_y;
      v.z = in_ch.vec_z;
      expected_rot.push_back(rotate_vec(v));
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_rot.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: %h %h %h", out_ch.rot_x, out_ch.rot_y, out_ch.rot_z);
      end else begin
        vec_t e;
        e = expected_rot.pop_front();
        if (e.x !== out_ch.rot_x || e.y !== out_ch.rot_y || e.z !== out_ch.rot_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("rotation mismatch: expected %h %h %h got %h %h %h",
                     e.x, e.y, e.z, out_ch.rot_x, out_ch.rot_y, out_ch.rot_z);
        end
      end
    end
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_vec(input logic [DW-1:0] x, input logic [DW-1:0] y,
                         input logic [DW-1:0] z);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    pending_vecs.push_back(v);
  endtask

  // component mix: full range, small magnitudes and edge values
  function automatic logic [DW-1:0] rand_comp();
    logic [DW-1:0] edges[6];
    edges = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1, 32'hffff_ffff, 32'h0000_8000};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom;
      6, 7: return $unsigned($signed($urandom_range(0, 2 * (1 << 20))) - (1 << 20));
      default: return edges[$urandom_range(0, 5)];
    endcase
  endfunction

  // wait until every sent word is back and the block has gone quiet
  task automatic drain();
    while (pending_vecs.size() > 0 || in_ch.valid || expected_rot.size() > 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // back-to-back angle writes while idle, model follows each one
  task automatic set_angles(input logic [ANGLE_W-1:0] roll, input logic [ANGLE_W-1:0] pitch,
                            input logic [ANGLE_W-1:0] yaw, input bit junk_write);
    logic [ANGLE_W-1:0] vals[3];
    vals = '{roll, pitch, yaw};
    for (int i = 0; i < 3; i++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data  <= vals[i];
      angle_q[i] = vals[i];
    end
    if (junk_write) begin
      // unused index must leave the matrix alone
      @(posedge clk);
      cfg_index <= REG_NONE;
      cfg_data  <= 16'($urandom);
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    build_rotation();
  endtask

  task automatic directed_vecs();
    add_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_vec(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    add_vec(32'h0, 32'h0, 32'h0);
    add_vec(32'h1, 32'hffff_ffff, 32'h0000_8000);
    add_vec(32'h0001_0000, 32'h0, 32'h0);
    add_vec(32'h0, 32'h0001_0000, 32'h0);
    add_vec(32'h0, 32'h0, 32'hffff_0000);
  endtask

  initial begin
    int rand_phase;
    in_ch.valid = 1'b0;
    in_ch.vec_x = '0;
    in_ch.vec_y = '0;
    in_ch.vec_z = '0;
    out_ch.ready = 1'b0;
    angle_q = '{default: '0};
    build_rotation();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // identity after reset, then 45 degree yaw where x = y overflows
    directed_vecs();
    drain();
    set_angles(16'd0, 16'd0, 16'd2880, 1'b1);
    directed_vecs();
    drain();

    // fixed extremes first, then random angles; idling mode by phase
    for (rand_phase = 0; rand_phase < 10; rand_phase++) begin
      case (rand_phase)
        0: set_angles(16'h7fff, 16'h8000, 16'hffff, 1'b0);
        1: set_angles(16'd23040, -16'sd23040, 16'd5760, 1'b1);
        2: set_angles(16'd11520, 16'd2881, -16'sd5760, 1'b0);
        3: set_angles(16'h8000, 16'h7fff, 16'd0, 1'b0);
        default: set_angles(16'($urandom), 16'($urandom), 16'($urandom), rand_phase[0]);
      endcase
      if (rand_phase < 4) begin
        idle_pct = 10; stall_pct = 68;
      end else if (rand_phase < 7) begin
        idle_pct = 68; stall_pct = 10;
      end else begin
        idle_pct = 0; stall_pct = 0;
      end
      for (int n = 0; n < 175; n++) add_vec(rand_comp(), rand_comp(), rand_comp());
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/evr_pkg.sv
sv/evr_in_if.sv
sv/evr_out_if.sv
sv/evr_trig.sv
sv/evr_coef.sv
sv/evr_lane.sv
sv/euler_vector_rotation.sv
tb/tb.sv
